// ----- rtl/mcr_pkg.sv -----
// mcr_pkg: shared constants, types and register map of the midpoint circle rasterizer.
// Used by mcr_front, mcr_fifo, mcr_back and midpoint_circle_rasterizer.
package mcr_pkg;

   localparam int MAX_DIM  = 4096;
   localparam int DIM_W    = 13;    // image_width / image_height register width
   localparam int COORD_W  = 13;    // step x / y
   localparam int CEN_W    = 14;    // signed centre coordinates
   localparam int DEC_W    = 18;    // signed decision variable
   localparam int SUM_W    = 16;    // signed centre +/- offset
   localparam int PIX_W    = 12;    // output row / column
   localparam int NSLOT    = 8;     // results a step can produce
   localparam int SLOT_W   = 3;
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = 2;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_CENTER_X  = 3'd0;
   localparam logic [2:0] REG_CENTER_Y  = 3'd1;
   localparam logic [2:0] REG_RADIUS    = 3'd2;
   localparam logic [2:0] REG_FILL_MODE = 3'd3;
   localparam logic [2:0] REG_WIDTH     = 3'd4;
   localparam logic [2:0] REG_HEIGHT    = 3'd5;

   typedef enum logic [1:0] {
      PH_DONE  = 2'd0,
      PH_RUN   = 2'd1,
      PH_FINAL = 2'd2
   } phase_type;

   // one decision-loop step handed from front to back
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               active;   // step draws octants
      logic               done;     // circle finished after this step
   } step_type;

   typedef struct packed {
      logic signed [CEN_W-1:0] center_x;
      logic signed [CEN_W-1:0] center_y;
      logic                    fill;
      logic [DIM_W-1:0]        width;
      logic [DIM_W-1:0]        height;
   } cfg_type;

endpackage

// ----- rtl/midpoint_circle_rasterizer.sv -----
// midpoint_circle_rasterizer: top level, register file, front/queue/back hookup.
// Depends on mcr_pkg, mcr_front, mcr_fifo, mcr_back.
// Path: an accepted item passes through the step queue and the back end's job registers to the output register.
// Throughput: one result per cycle while rsp_tready is high; a step gives up to 8 outline
//   points or 4 fill spans, or 1 status result; 4-entry queue: one item per cycle until full.
// Reset: synchronous, active high; clears loop state, queue and output, registers to defaults.
module midpoint_circle_rasterizer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // restart[0], zero [7:1]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // row[11:0], col_first[23:12], col_end[35:24], zero [39:36]
   output logic [1:0]  rsp_tuser,    // item_valid[0], done_res[1]
   output logic        rsp_tlast,
   // configuration
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [mcr_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [mcr_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [mcr_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);

   logic [mcr_pkg::CEN_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [mcr_pkg::COORD_W-1:0] rad_ff, rad_in;
   logic                        fill_ff, fill_in;
   logic [mcr_pkg::DIM_W-1:0]   w_ff, w_in, h_ff, h_in;
   logic                        wr_en;
   logic [2:0]                  reg_idx;

   mcr_pkg::cfg_type  cfg;
   mcr_pkg::step_type q_entry, q_head;
   logic              q_push, q_full, q_pop, q_head_valid;

   // ---- register file: write on access phase, pready always high ----
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[mcr_pkg::ADDR_W-1:2];

   always_comb begin
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      rad_in  = rad_ff;
      fill_in = fill_ff;
      w_in    = w_ff;
      h_in    = h_ff;
      if (wr_en) begin
         case (reg_idx)
            mcr_pkg::REG_CENTER_X:  cx_in   = csr_pwdata[mcr_pkg::CEN_W-1:0];
            mcr_pkg::REG_CENTER_Y:  cy_in   = csr_pwdata[mcr_pkg::CEN_W-1:0];
            mcr_pkg::REG_RADIUS:    rad_in  = csr_pwdata[mcr_pkg::COORD_W-1:0];
            mcr_pkg::REG_FILL_MODE: fill_in = csr_pwdata[0];
            mcr_pkg::REG_WIDTH:     w_in    = csr_pwdata[mcr_pkg::DIM_W-1:0];
            mcr_pkg::REG_HEIGHT:    h_in    = csr_pwdata[mcr_pkg::DIM_W-1:0];
            default: ;   // unmapped index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff   <= '0;
         cy_ff   <= '0;
         rad_ff  <= '0;
         fill_ff <= 1'b0;
         w_ff    <= mcr_pkg::DIM_W'(mcr_pkg::MAX_DIM);
         h_ff    <= mcr_pkg::DIM_W'(mcr_pkg::MAX_DIM);
      end else begin
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         rad_ff  <= rad_in;
         fill_ff <= fill_in;
         w_ff    <= w_in;
         h_ff    <= h_in;
      end
   end

   always_comb begin
      case (reg_idx)
         mcr_pkg::REG_CENTER_X:  csr_prdata = mcr_pkg::DATA_W'({cx_ff});
         mcr_pkg::REG_CENTER_Y:  csr_prdata = mcr_pkg::DATA_W'({cy_ff});
         mcr_pkg::REG_RADIUS:    csr_prdata = mcr_pkg::DATA_W'({rad_ff});
         mcr_pkg::REG_FILL_MODE: csr_prdata = mcr_pkg::DATA_W'({fill_ff});
         mcr_pkg::REG_WIDTH:     csr_prdata = mcr_pkg::DATA_W'({w_ff});
         mcr_pkg::REG_HEIGHT:    csr_prdata = mcr_pkg::DATA_W'({h_ff});
         default:                csr_prdata = '0;
      endcase
   end

   // centre, fill and image size are read live by the back end; the config port is
   // to be written only while the pipe is empty, which the block does not enforce
   assign cfg.center_x = cx_ff;
   assign cfg.center_y = cy_ff;
   assign cfg.fill     = fill_ff;
   assign cfg.width    = w_ff;
   assign cfg.height   = h_ff;

   // ---- front: decision loop, one step per accepted item ----
   mcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .restart    (req_tdata[0]),
      .radius     (rad_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   // ---- step queue ----
   mcr_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head       (q_head)
   );

   // ---- back: clip and emit points / spans ----
   mcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head       (q_head),
      .head_pop   (q_pop),
      .cfg        (cfg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ---- assertions ----
   // status-only result always closes its item
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("status result without tlast");

   // status-only result carries zero coordinates
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == '0))
      else $error("status result with nonzero payload");

   // clipped span is never inverted
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[23:12] <= rsp_tdata[35:24]))
      else $error("col_first beyond col_end");

   // nothing left in the output register after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// ----- rtl/mcr_front.sv -----
// mcr_front: midpoint decision loop, one step per accepted item.
// Depends on mcr_pkg; feeds mcr_fifo.
module mcr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          restart,
   input  logic [mcr_pkg::COORD_W-1:0]   radius,
   input  logic                          q_full,
   output logic                          q_push,
   output mcr_pkg::step_type             q_entry
);

   logic [mcr_pkg::COORD_W-1:0]      x_ff, x_in, y_ff, y_in;
   logic signed [mcr_pkg::DEC_W-1:0] d_ff, d_in;
   mcr_pkg::phase_type               phase_ff, phase_in;

   logic [mcr_pkg::COORD_W-1:0]      x_cur, y_cur, x_nx, y_nx;
   logic signed [mcr_pkg::DEC_W-1:0] d_cur, d_nx;
   mcr_pkg::phase_type               ph_cur, ph_nx;
   logic                             accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // restart loads x=0, y=r, d=3-2r before the step
   always_comb begin
      if (restart) begin
         x_cur  = '0;
         y_cur  = radius;
         d_cur  = mcr_pkg::DEC_W'(3) - mcr_pkg::DEC_W'({radius, 1'b0});
         ph_cur = (radius != '0) ? mcr_pkg::PH_RUN : mcr_pkg::PH_FINAL;
      end else begin
         x_cur  = x_ff;
         y_cur  = y_ff;
         d_cur  = d_ff;
         ph_cur = phase_ff;
      end
   end

   always_comb begin
      x_nx  = x_cur;
      y_nx  = y_cur;
      d_nx  = d_cur;
      ph_nx = mcr_pkg::PH_DONE;
      case (ph_cur)
         mcr_pkg::PH_RUN: begin
            if (d_cur < 0) begin
               d_nx = d_cur + mcr_pkg::DEC_W'({x_cur, 2'b00}) + mcr_pkg::DEC_W'(6);
            end else begin
               d_nx = d_cur
                    + mcr_pkg::DEC_W'({x_cur, 2'b00})
                    - mcr_pkg::DEC_W'({y_cur, 2'b00})
                    + mcr_pkg::DEC_W'(10);
               y_nx = y_cur - 1'b1;
            end
            x_nx = x_cur + 1'b1;
            if (x_nx < y_nx)       ph_nx = mcr_pkg::PH_RUN;
            else if (x_nx == y_nx) ph_nx = mcr_pkg::PH_FINAL;
            else                   ph_nx = mcr_pkg::PH_DONE;
         end
         mcr_pkg::PH_FINAL: ph_nx = mcr_pkg::PH_DONE;
         default:           ph_nx = mcr_pkg::PH_DONE;
      endcase
   end

   always_comb begin
      x_in     = accept ? x_nx  : x_ff;
      y_in     = accept ? y_nx  : y_ff;
      d_in     = accept ? d_nx  : d_ff;
      phase_in = accept ? ph_nx : phase_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff     <= '0;
         y_ff     <= '0;
         d_ff     <= '0;
         phase_ff <= mcr_pkg::PH_DONE;
      end else begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         d_ff     <= d_in;
         phase_ff <= phase_in;
      end
   end

   assign q_push         = accept;
   assign q_entry.x      = x_cur;
   assign q_entry.y      = y_cur;
   assign q_entry.active = (ph_cur == mcr_pkg::PH_RUN) || (ph_cur == mcr_pkg::PH_FINAL);
   assign q_entry.done   = (ph_nx == mcr_pkg::PH_DONE);

endmodule

// ----- rtl/mcr_fifo.sv -----
// mcr_fifo: short show-ahead queue of loop steps between front and back.
// Depends on mcr_pkg.
module mcr_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mcr_pkg::step_type push_entry,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output mcr_pkg::step_type head
);

   mcr_pkg::step_type           mem_ff [mcr_pkg::QDEPTH];
   logic [mcr_pkg::QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [mcr_pkg::QPTR_W:0]    cnt_ff, cnt_in;
   logic                        do_push, do_pop;

   assign full       = (cnt_ff == (mcr_pkg::QPTR_W+1)'(mcr_pkg::QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/mcr_back.sv -----
// mcr_back: expands a step into clipped points or spans; one result per unstalled cycle.
// Depends on mcr_pkg; pops mcr_fifo, drives the result output register.
module mcr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  mcr_pkg::step_type head,
   output logic              head_pop,
   input  mcr_pkg::cfg_type  cfg,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // row[11:0], col_first[23:12], col_end[35:24], 0
   output logic [1:0]        rsp_tuser,   // item_valid[0], done_res[1]
   output logic              rsp_tlast
);

   logic signed [mcr_pkg::SUM_W-1:0] cx, cy, xs, ys, wm1, hh;
   logic signed [mcr_pkg::SUM_W-1:0] cxpy, cxmy, cxpx, cxmx, cypx, cymx, cypy, cymy;
   logic signed [mcr_pkg::SUM_W-1:0] c_row [mcr_pkg::NSLOT];
   logic signed [mcr_pkg::SUM_W-1:0] c_lo  [mcr_pkg::NSLOT];
   logic signed [mcr_pkg::SUM_W-1:0] c_hi  [mcr_pkg::NSLOT];
   logic signed [mcr_pkg::SUM_W-1:0] lo_c  [mcr_pkg::NSLOT];
   logic signed [mcr_pkg::SUM_W-1:0] hi_c  [mcr_pkg::NSLOT];
   logic [mcr_pkg::NSLOT-1:0] c_ok;
   logic [mcr_pkg::DIM_W-1:0] w_eff, h_eff;

   logic                      job_valid_ff, job_valid_in;
   logic [mcr_pkg::NSLOT-1:0] mask_ff, mask_in;
   logic                      done_ff, done_in;
   logic [mcr_pkg::PIX_W-1:0] row_ff [mcr_pkg::NSLOT];
   logic [mcr_pkg::PIX_W-1:0] c0_ff  [mcr_pkg::NSLOT];
   logic [mcr_pkg::PIX_W-1:0] c1_ff  [mcr_pkg::NSLOT];

   logic                      ov_ff, ov_in;
   logic [39:0]               od_ff, od_in;
   logic [1:0]                ou_ff, ou_in;
   logic                      ol_ff, ol_in;

   logic                      out_free, emit, last, finish, load;
   logic [mcr_pkg::NSLOT-1:0] pick, mask_nx;
   logic [mcr_pkg::SLOT_W-1:0] idx;

   // ---- candidate geometry of the queue head ----
   always_comb begin
      cx    = mcr_pkg::SUM_W'($signed(cfg.center_x));
      cy    = mcr_pkg::SUM_W'($signed(cfg.center_y));
      xs    = mcr_pkg::SUM_W'({1'b0, head.x});
      ys    = mcr_pkg::SUM_W'({1'b0, head.y});
      w_eff = (cfg.width  > mcr_pkg::DIM_W'(mcr_pkg::MAX_DIM))
              ? mcr_pkg::DIM_W'(mcr_pkg::MAX_DIM) : cfg.width;
      h_eff = (cfg.height > mcr_pkg::DIM_W'(mcr_pkg::MAX_DIM))
              ? mcr_pkg::DIM_W'(mcr_pkg::MAX_DIM) : cfg.height;
      wm1   = mcr_pkg::SUM_W'({1'b0, w_eff}) - mcr_pkg::SUM_W'(1);
      hh    = mcr_pkg::SUM_W'({1'b0, h_eff});
      cxpy  = cx + ys;
      cxmy  = cx - ys;
      cxpx  = cx + xs;
      cxmx  = cx - xs;
      cypx  = cy + xs;
      cymx  = cy - xs;
      cypy  = cy + ys;
      cymy  = cy - ys;
      if (cfg.fill) begin
         c_row[0] = cypy; c_lo[0] = cxmx; c_hi[0] = cxpx;
         c_row[1] = cymy; c_lo[1] = cxmx; c_hi[1] = cxpx;
         c_row[2] = cypx; c_lo[2] = cxmy; c_hi[2] = cxpy;
         c_row[3] = cymx; c_lo[3] = cxmy; c_hi[3] = cxpy;
         for (int k = 4; k < mcr_pkg::NSLOT; k++) begin
            c_row[k] = '0; c_lo[k] = '0; c_hi[k] = '0;
         end
      end else begin
         c_row[0] = cymx; c_lo[0] = cxpy; c_hi[0] = cxpy;
         c_row[1] = cypx; c_lo[1] = cxpy; c_hi[1] = cxpy;
         c_row[2] = cymx; c_lo[2] = cxmy; c_hi[2] = cxmy;
         c_row[3] = cypx; c_lo[3] = cxmy; c_hi[3] = cxmy;
         c_row[4] = cymy; c_lo[4] = cxpx; c_hi[4] = cxpx;
         c_row[5] = cypy; c_lo[5] = cxpx; c_hi[5] = cxpx;
         c_row[6] = cymy; c_lo[6] = cxmx; c_hi[6] = cxmx;
         c_row[7] = cypy; c_lo[7] = cxmx; c_hi[7] = cxmx;
      end
      // a point is a one-pixel span: the same clip covers both modes
      for (int k = 0; k < mcr_pkg::NSLOT; k++) begin
         lo_c[k] = (c_lo[k] < 0)   ? mcr_pkg::SUM_W'(0) : c_lo[k];
         hi_c[k] = (c_hi[k] > wm1) ? wm1                : c_hi[k];
         c_ok[k] = head.active && (!cfg.fill || (k < 4))
                && (c_row[k] >= 0) && (c_row[k] < hh) && (w_eff != '0)
                && (lo_c[k] <= hi_c[k]);
      end
   end

   // ---- emit sequencer ----
   always_comb begin
      out_free = !ov_ff || rsp_tready;
      emit     = job_valid_ff && out_free;
      pick     = mask_ff & (~mask_ff + 1'b1);
      mask_nx  = mask_ff & ~pick;
      last     = (mask_nx == '0);
      finish   = emit && last;
      load     = head_valid && (!job_valid_ff || finish);
      idx      = '0;
      for (int k = 0; k < mcr_pkg::NSLOT; k++) begin
         if (pick[k]) idx = mcr_pkg::SLOT_W'(k);
      end
   end

   assign head_pop = load;

   always_comb begin
      job_valid_in = job_valid_ff;
      mask_in      = mask_ff;
      done_in      = done_ff;
      if (load) begin
         job_valid_in = 1'b1;
         mask_in      = c_ok;
         done_in      = head.done;
      end else if (finish) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         mask_in      = mask_nx;
      end
   end

   always_comb begin
      ov_in = ov_ff;
      od_in = od_ff;
      ou_in = ou_ff;
      ol_in = ol_ff;
      if (emit) begin
         ov_in = 1'b1;
         ol_in = last;
         if (mask_ff == '0) begin
            od_in = '0;
            ou_in = {done_ff, 1'b0};
         end else begin
            od_in = {4'b0000, c1_ff[idx], c0_ff[idx], row_ff[idx]};
            ou_in = {done_ff, 1'b1};
         end
      end else if (rsp_tready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         mask_ff      <= '0;
         done_ff      <= 1'b0;
         ov_ff        <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         mask_ff      <= mask_in;
         done_ff      <= done_in;
         ov_ff        <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      od_ff <= od_in;
      ou_ff <= ou_in;
      ol_ff <= ol_in;
      if (load) begin
         for (int k = 0; k < mcr_pkg::NSLOT; k++) begin
            row_ff[k] <= c_row[k][mcr_pkg::PIX_W-1:0];
            c0_ff[k]  <= lo_c[k][mcr_pkg::PIX_W-1:0];
            c1_ff[k]  <= hi_c[k][mcr_pkg::PIX_W-1:0];
         end
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ou_ff;
   assign rsp_tlast  = ol_ff;

endmodule
